@@ design/bvc_pkg.sv @@
`default_nettype none

package bvc_pkg;

	// Fixed widths of the request and result fields.
	localparam int COUNT_W  = 16;
	localparam int FINE_W   = 16;
	localparam int FCODE_W  = 11;
	localparam int STEP_W   = 8;
	localparam int FOLD_W   = 10;
	localparam int COARSE_W = 4;
	localparam int SPEED_W  = 5;

	// Saturation limits of the coarse DAC and the speed band.
	localparam logic [COARSE_W-1:0] COARSE_TOP = 4'd15;
	localparam logic [SPEED_W-1:0]  SPEED_TOP  = 5'd31;

	// Configuration port layout.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLD_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE_HIGH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE_START   = 3'd5;

	// Register values after reset.
	localparam logic [COUNT_W-1:0] RST_TARGET_COUNT = 16'd0;
	localparam logic [STEP_W-1:0]  RST_FINE_STEP    = 8'd32;
	localparam logic [FOLD_W-1:0]  RST_FOLD_OFFSET  = 10'd300;
	localparam logic [FCODE_W-1:0] RST_FINE_LOW     = 11'd896;
	localparam logic [FCODE_W-1:0] RST_FINE_HIGH    = 11'd1152;
	localparam logic [FCODE_W-1:0] RST_FINE_START   = 11'd1024;

	// Command codes of a request.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LEVEL = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;

	// Codes of the next measurement wanted.
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_LEVEL = 2'd1;
	localparam logic [1:0] REQ_COUNT = 2'd2;

	// Remainder unit operand widths.
	localparam int DIV_NUM_W = FCODE_W;
	localparam int DIV_DEN_W = STEP_W;

	typedef struct packed {
		logic [1:0]         command;
		logic               over_threshold;
		logic [COUNT_W-1:0] freq_count;
	} cmd_t;

	typedef struct packed {
		logic [SPEED_W-1:0]  speed_band;
		logic [COARSE_W-1:0] coarse_code;
		logic [FCODE_W-1:0]  fine_code;
		logic                dac_update;
		logic [1:0]          next_request;
		logic                cal_done;
	} rslt_t;

	typedef struct packed {
		logic [COUNT_W-1:0] target_count;
		logic [STEP_W-1:0]  fine_step;
		logic [FOLD_W-1:0]  fold_offset;
		logic [FCODE_W-1:0] fine_low;
		logic [FCODE_W-1:0] fine_high;
		logic [FCODE_W-1:0] fine_start;
	} cfg_t;

	// Remainder request from the update logic to the remainder unit.
	typedef struct packed {
		logic                 need;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

endpackage

`default_nettype wire

@@ design/bvc_cfg_regs.sv @@
`default_nettype none

module bvc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bvc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bvc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output bvc_pkg::cfg_t                        cfg
);

	bvc_pkg::cfg_t cfg_q;

	// Register file with index decode; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_count <= bvc_pkg::RST_TARGET_COUNT;
			cfg_q.fine_step    <= bvc_pkg::RST_FINE_STEP;
			cfg_q.fold_offset  <= bvc_pkg::RST_FOLD_OFFSET;
			cfg_q.fine_low     <= bvc_pkg::RST_FINE_LOW;
			cfg_q.fine_high    <= bvc_pkg::RST_FINE_HIGH;
			cfg_q.fine_start   <= bvc_pkg::RST_FINE_START;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bvc_pkg::CFG_TARGET_COUNT: cfg_q.target_count <= cfg_wdata;
				bvc_pkg::CFG_FINE_STEP:    cfg_q.fine_step <= cfg_wdata[bvc_pkg::STEP_W-1:0];
				bvc_pkg::CFG_FOLD_OFFSET:  cfg_q.fold_offset <= cfg_wdata[bvc_pkg::FOLD_W-1:0];
				bvc_pkg::CFG_FINE_LOW:     cfg_q.fine_low <= cfg_wdata[bvc_pkg::FCODE_W-1:0];
				bvc_pkg::CFG_FINE_HIGH:    cfg_q.fine_high <= cfg_wdata[bvc_pkg::FCODE_W-1:0];
				bvc_pkg::CFG_FINE_START:   cfg_q.fine_start <= cfg_wdata[bvc_pkg::FCODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ design/bvc_rem_div.sv @@
`default_nettype none

module bvc_rem_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic                           clear,
	input  wire logic [bvc_pkg::DIV_NUM_W-1:0]  num,
	input  wire logic [bvc_pkg::DIV_DEN_W-1:0]  den,
	output logic      [bvc_pkg::DIV_DEN_W-1:0]  rem,
	output logic                                rem_valid
);

	localparam int NUM_W = bvc_pkg::DIV_NUM_W;
	localparam int DEN_W = bvc_pkg::DIV_DEN_W;
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} dv_state_t;

	dv_state_t        state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_next = trial - {1'b0, den_q};
		end else begin
			rem_next = trial;
		end
	end

	// Sequencer: one dividend bit per cycle, result held until cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			num_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						num_q   <= num;
						den_q   <= den;
						rem_q   <= '0;
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					rem_q <= rem_next[DEN_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= DV_DONE;
					end
				end
				DV_DONE: begin
					if (clear) begin
						state_q <= DV_IDLE;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	assign rem       = rem_q;
	assign rem_valid = (state_q == DV_DONE);

endmodule

`default_nettype wire

@@ design/bvc_core.sv @@
`default_nettype none

module bvc_core #(
	parameter logic [bvc_pkg::COARSE_W-1:0] COARSE_TOP = bvc_pkg::COARSE_TOP,
	parameter logic [bvc_pkg::SPEED_W-1:0]  SPEED_TOP  = bvc_pkg::SPEED_TOP
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bvc_pkg::cmd_t                 cmd,
	input  wire logic                          fire,
	input  wire bvc_pkg::cfg_t                 cfg,
	input  wire logic [bvc_pkg::DIV_DEN_W-1:0] rem,
	output bvc_pkg::div_req_t                  div_req,
	output bvc_pkg::rslt_t                     rslt
);

	localparam int FINE_W   = bvc_pkg::FINE_W;
	localparam int FCODE_W  = bvc_pkg::FCODE_W;
	localparam int COARSE_W = bvc_pkg::COARSE_W;
	localparam int SPEED_W  = bvc_pkg::SPEED_W;
	localparam int STEP_W   = bvc_pkg::STEP_W;
	localparam int FOLD_W   = bvc_pkg::FOLD_W;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COARSE,
		PH_SPEED,
		PH_SPILL,
		PH_STEPDOWN,
		PH_TRIM,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [FINE_W-1:0]   fine;
		logic [COARSE_W-1:0] coarse;
	} fold_t;

	// Move fold_offset of fine into or out of one coarse step.
	function automatic fold_t fold_fine(input logic [FINE_W-1:0] fi,
			input logic [COARSE_W-1:0] co, input bvc_pkg::cfg_t c);
		fold_t r;
		r.fine   = fi;
		r.coarse = co;
		if (fi < {{(FINE_W-FCODE_W){1'b0}}, c.fine_low}) begin
			r.fine = fi + {{(FINE_W-FOLD_W){1'b0}}, c.fold_offset};
			if (co != '0) begin
				r.coarse = co - COARSE_W'(1);
			end
		end else if (fi > {{(FINE_W-FCODE_W){1'b0}}, c.fine_high}) begin
			r.fine = fi - {{(FINE_W-FOLD_W){1'b0}}, c.fold_offset};
			if (co < COARSE_TOP) begin
				r.coarse = co + COARSE_W'(1);
			end
		end
		return r;
	endfunction

	phase_t              phase_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [COARSE_W-1:0] coarse_q;
	logic [FINE_W-1:0]   fine_q;
	logic [FCODE_W-1:0]  fwr_q;
	bvc_pkg::rslt_t      rslt_q;

	phase_t              ph;
	logic [SPEED_W-1:0]  sp;
	logic [COARSE_W-1:0] co;
	logic [FINE_W-1:0]   fi;
	logic [FCODE_W-1:0]  fw;
	logic                upd;
	logic                go;
	logic                do_step;
	logic                do_check;
	logic                need;
	logic [FCODE_W-1:0]  num;
	logic [STEP_W-1:0]   pad;
	logic [FINE_W-1:0]   step_x;
	logic [FINE_W-1:0]   high_x;
	logic [1:0]          req;
	fold_t               fr;

	assign step_x = {{(FINE_W-STEP_W){1'b0}}, cfg.fine_step};
	assign high_x = {{(FINE_W-FCODE_W){1'b0}}, cfg.fine_high};

	// Next state and result for the request held in the input register.
	always_comb begin
		ph       = phase_q;
		sp       = speed_q;
		co       = coarse_q;
		fi       = fine_q;
		fw       = fwr_q;
		upd      = 1'b0;
		go       = 1'b0;
		do_step  = 1'b0;
		do_check = 1'b0;
		need     = 1'b0;
		num      = '0;
		pad      = '0;
		fr       = '0;

		case (cmd.command)
			bvc_pkg::CMD_START: begin
				sp  = '0;
				co  = '0;
				fi  = {{(FINE_W-FCODE_W){1'b0}}, cfg.fine_start};
				fw  = cfg.fine_start;
				upd = 1'b1;
				ph  = PH_COARSE;
			end
			bvc_pkg::CMD_LEVEL: begin
				if (phase_q == PH_COARSE) begin
					if (cmd.over_threshold) begin
						ph = PH_SPEED;
					end else begin
						if (co < COARSE_TOP) begin
							co = co + COARSE_W'(1);
						end
						upd = 1'b1;
						ph  = (co < COARSE_TOP) ? PH_COARSE : PH_SPEED;
					end
				end else if (phase_q == PH_SPILL) begin
					go = ((co < COARSE_TOP) && !cmd.over_threshold) ||
						(sp == SPEED_TOP);
					if (!go) begin
						ph = PH_SPEED;
					end else begin
						if (co < COARSE_TOP) begin
							co = co + COARSE_W'(1);
						end
						upd      = 1'b1;
						do_check = 1'b1;
						// Coarse is used up: spill one step into fine.
						if (co >= COARSE_TOP) begin
							if (fi < high_x) begin
								fi = fi + step_x;
								fw = fi[FCODE_W-1:0];
							end else begin
								ph       = PH_TRIM;
								do_check = 1'b0;
							end
						end
					end
				end
			end
			bvc_pkg::CMD_COUNT: begin
				if (phase_q == PH_SPEED) begin
					if (cmd.freq_count >= cfg.target_count) begin
						do_step = 1'b1;
					end else begin
						if (sp < SPEED_TOP) begin
							sp = sp + SPEED_W'(1);
						end
						do_check = 1'b1;
					end
				end else if (phase_q == PH_STEPDOWN) begin
					if (cmd.freq_count <= cfg.target_count) begin
						ph = PH_TRIM;
					end else begin
						do_step = 1'b1;
					end
				end else if (phase_q == PH_TRIM) begin
					if (cmd.freq_count == cfg.target_count) begin
						ph = PH_DONE;
					end else begin
						if (cmd.freq_count > cfg.target_count) begin
							fi = fi - step_x;
						end else begin
							fi = fi + step_x;
						end
						fr  = fold_fine(fi, co, cfg);
						fi  = fr.fine;
						co  = fr.coarse;
						fw  = fi[FCODE_W-1:0];
						upd = 1'b1;
						if (!((fi != '0) && (fi < high_x))) begin
							ph = PH_DONE;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// Step fine down; fine reaches the DAC only with coarse strictly inside.
		if (do_step) begin
			if (fi == '0) begin
				ph = PH_TRIM;
			end else begin
				fi = fi - step_x;
				if ((co != '0) && (co < COARSE_TOP)) begin
					fr  = fold_fine(fi, co, cfg);
					fi  = fr.fine;
					co  = fr.coarse;
					fw  = fi[FCODE_W-1:0];
					upd = 1'b1;
				end
				ph = PH_STEPDOWN;
			end
		end

		// Spill decision; with speed and coarse at maximum, fine climbs to the
		// first step position at or above fine_high, found from the remainder.
		if (do_check) begin
			if (co < COARSE_TOP) begin
				ph = PH_SPILL;
			end else if (sp == SPEED_TOP) begin
				upd = 1'b1;
				if ((cfg.fine_step != '0) && (fi < high_x)) begin
					need = 1'b1;
					num  = cfg.fine_high - fi[FCODE_W-1:0];
					pad  = (rem == '0) ? '0 : (cfg.fine_step - rem);
					fi   = high_x + {{(FINE_W-STEP_W){1'b0}}, pad};
					fw   = fi[FCODE_W-1:0];
				end
				ph = PH_TRIM;
			end else begin
				ph = PH_SPEED;
			end
		end

		if ((ph == PH_COARSE) || (ph == PH_SPILL)) begin
			req = bvc_pkg::REQ_LEVEL;
		end else if ((ph == PH_SPEED) || (ph == PH_STEPDOWN) || (ph == PH_TRIM)) begin
			req = bvc_pkg::REQ_COUNT;
		end else begin
			req = bvc_pkg::REQ_NONE;
		end
	end

	assign div_req.need = need;
	assign div_req.num  = num;
	assign div_req.den  = cfg.fine_step;

	// Calibration state, updated when a request is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			speed_q  <= '0;
			coarse_q <= '0;
			fine_q   <= '0;
			fwr_q    <= '0;
		end else if (fire) begin
			phase_q  <= ph;
			speed_q  <= sp;
			coarse_q <= co;
			fine_q   <= fi;
			fwr_q    <= fw;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			rslt_q.speed_band   <= sp;
			rslt_q.coarse_code  <= co;
			rslt_q.fine_code    <= fw;
			rslt_q.dac_update   <= upd;
			rslt_q.next_request <= req;
			rslt_q.cal_done     <= (ph == PH_DONE);
		end
	end

	assign rslt = rslt_q;

endmodule

`default_nettype wire

@@ design/pll_vco_band_calibrator.sv @@
// Calibration sequencer for a ring-oscillator PLL. Send a start command, then
// answer each result's next_request with a level sample (command 1) or a
// frequency count (command 2); every request yields exactly one result with
// the current speed band, coarse code and fine DAC code, a DAC strobe flag
// and cal_done once the trim has converged. Requests pass through an input
// register and one stage of update logic into a result register, so one
// request per cycle is taken while the result side keeps up. The one
// exception is the fine climb taken when coarse and speed both sit at their
// maximum: its step count comes from a bit-serial remainder unit, one
// dividend bit per cycle, and that request waits for it. COARSE_TOP
// and SPEED_TOP set where the coarse code and the speed band saturate. Write
// the configuration registers only while no request is in flight.
`default_nettype none

module pll_vco_band_calibrator #(
	parameter logic [bvc_pkg::COARSE_W-1:0] COARSE_TOP = bvc_pkg::COARSE_TOP,
	parameter logic [bvc_pkg::SPEED_W-1:0]  SPEED_TOP  = bvc_pkg::SPEED_TOP
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_ready,
	input  wire bvc_pkg::cmd_t                  cmd_data,
	output logic                                rslt_valid,
	input  wire logic                           rslt_ready,
	output bvc_pkg::rslt_t                      rslt_data,
	input  wire logic                           cfg_we,
	input  wire logic [bvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bvc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	bvc_pkg::cfg_t                     cfg;
	bvc_pkg::cmd_t                     cmd_s1;
	logic                              cmd_valid_s1;
	logic                              rslt_valid_q;
	bvc_pkg::div_req_t                 div_req;
	logic [bvc_pkg::DIV_DEN_W-1:0]     rem;
	logic                              rem_valid;
	logic                              can_load;
	logic                              fire;
	logic                              div_start;

	bvc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The held request is processed once the result register is free and any
	// remainder it needs is ready.
	assign can_load  = !rslt_valid_q || rslt_ready;
	assign fire      = cmd_valid_s1 && can_load && (!div_req.need || rem_valid);
	assign div_start = cmd_valid_s1 && div_req.need && !rem_valid;
	assign cmd_ready = !cmd_valid_s1 || fire;

	bvc_rem_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.clear     (fire),
		.num       (div_req.num),
		.den       (div_req.den),
		.rem       (rem),
		.rem_valid (rem_valid)
	);

	bvc_core #(
		.COARSE_TOP (COARSE_TOP),
		.SPEED_TOP  (SPEED_TOP)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_s1),
		.fire    (fire),
		.cfg     (cfg),
		.rem     (rem),
		.div_req (div_req),
		.rslt    (rslt_data)
	);

	// Input register valid and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			rslt_valid_q <= 1'b0;
		end else begin
			if (cmd_ready) begin
				cmd_valid_s1 <= cmd_valid;
			end
			if (fire) begin
				rslt_valid_q <= 1'b1;
			end else if (rslt_ready) begin
				rslt_valid_q <= 1'b0;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd_data;
		end
	end

	assign rslt_valid = rslt_valid_q;

	// A remainder is only ever held for the request waiting in the input register.
	a_rem_owned: assert property (@(posedge clk) disable iff (!arst_n)
		rem_valid |-> cmd_valid_s1)
		else $error("remainder held with no request waiting");

	// A start request always produces a strobed result asking for a level sample.
	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_s1.command == bvc_pkg::CMD_START)) |=>
		(rslt_valid && rslt_data.dac_update &&
		 (rslt_data.next_request == bvc_pkg::REQ_LEVEL) &&
		 (rslt_data.speed_band == '0) && (rslt_data.coarse_code == '0)))
		else $error("start request gave a wrong result");

	// A finished calibration requests no further measurement.
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(rslt_valid && rslt_data.cal_done) |-> (rslt_data.next_request == bvc_pkg::REQ_NONE))
		else $error("done result still requests a measurement");

	// Every processed request shows up as a result in the next cycle.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rslt_valid)
		else $error("processed request produced no result");

endmodule

`default_nettype wire

@@ tb/bvc_code_checker.sv @@
`default_nettype none

module bvc_code_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	input  wire logic                           cmd_ready,
	input  wire bvc_pkg::cmd_t                  cmd_data,
	input  wire logic                           rslt_valid,
	input  wire logic                           rslt_ready,
	input  wire bvc_pkg::rslt_t                 rslt_data,
	input  wire logic                           cfg_we,
	input  wire logic [bvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bvc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                  n_fail,
	output int                                  n_pending,
	output bvc_pkg::rslt_t                      predicted
);
	timeunit 1ns;
	timeprecision 1ps;

	import bvc_pkg::*;

	typedef enum logic [2:0] {
		CAL_IDLE,
		CAL_COARSE,
		CAL_SPEED,
		CAL_SPILL,
		CAL_STEPDOWN,
		CAL_TRIM,
		CAL_DONE
	} cal_phase_t;

	// Shadow of the configuration registers and of the calibration state.
	cfg_t                cfg;
	cal_phase_t          cal_ph;
	logic [SPEED_W-1:0]  speed_q;
	logic [COARSE_W-1:0] coarse_q;
	logic [FINE_W-1:0]   fine_q;
	logic [FCODE_W-1:0]  fine_dac;
	logic                strobe;

	// Results still owed by the block, oldest first.
	rslt_t codes_due[$];

	task automatic report(input string msg);
		n_fail++;
		$display("checker: %0t ns: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// The fine DAC word only changes when the sequencer writes it.
	function automatic void write_fine();
		fine_dac = fine_q[FCODE_W-1:0];
		strobe = 1'b1;
	endfunction

	// Trade fine range for one coarse step in either direction.
	function automatic void fold_fine();
		if (fine_q < cfg.fine_low) begin
			fine_q = fine_q + cfg.fold_offset;
			if (coarse_q != '0) coarse_q--;
		end else if (fine_q > cfg.fine_high) begin
			fine_q = fine_q - cfg.fold_offset;
			if (coarse_q < COARSE_TOP) coarse_q++;
		end
	endfunction

	// One fine step down; the DAC is only touched while coarse has room both ways.
	function automatic void step_down();
		if (fine_q == '0) begin
			cal_ph = CAL_TRIM;
			return;
		end
		fine_q = fine_q - cfg.fine_step;
		if (coarse_q > '0 && coarse_q < COARSE_TOP) begin
			fold_fine();
			write_fine();
		end
		cal_ph = CAL_STEPDOWN;
	endfunction

	// Decide where a speed or spill step goes next; with everything at its
	// maximum, fine climbs in whole steps to the first position at or above fine_high and trim begins.
	function automatic void after_spill();
		int n;
		if (coarse_q < COARSE_TOP) begin
			cal_ph = CAL_SPILL;
		end else if (speed_q == SPEED_TOP) begin
			strobe = 1'b1;
			if (cfg.fine_step != '0 && fine_q < cfg.fine_high) begin
				n = (int'(cfg.fine_high) - int'(fine_q) + int'(cfg.fine_step) - 1)
					/ int'(cfg.fine_step);
				fine_q = 16'(int'(fine_q) + n * int'(cfg.fine_step));
				write_fine();
			end
			cal_ph = CAL_TRIM;
		end else begin
			cal_ph = CAL_SPEED;
		end
	endfunction

	function automatic void take_level(input logic over);
		logic go;
		if (cal_ph == CAL_COARSE) begin
			if (over) begin
				cal_ph = CAL_SPEED;
				return;
			end
			if (coarse_q < COARSE_TOP) coarse_q++;
			strobe = 1'b1;
			cal_ph = (coarse_q < COARSE_TOP) ? CAL_COARSE : CAL_SPEED;
		end else if (cal_ph == CAL_SPILL) begin
			go = (coarse_q < COARSE_TOP && !over) || speed_q == SPEED_TOP;
			if (!go) begin
				cal_ph = CAL_SPEED;
				return;
			end
			if (coarse_q < COARSE_TOP) coarse_q++;
			strobe = 1'b1;
			if (coarse_q >= COARSE_TOP) begin
				if (fine_q < cfg.fine_high) begin
					fine_q = fine_q + cfg.fine_step;
					write_fine();
				end else begin
					cal_ph = CAL_TRIM;
					return;
				end
			end
			after_spill();
		end
	endfunction

	function automatic void take_count(input logic [COUNT_W-1:0] cnt);
		case (cal_ph)
			CAL_SPEED: begin
				if (cnt >= cfg.target_count) begin
					step_down();
				end else begin
					if (speed_q < SPEED_TOP) speed_q++;
					after_spill();
				end
			end
			CAL_STEPDOWN: begin
				if (cnt <= cfg.target_count) cal_ph = CAL_TRIM;
				else step_down();
			end
			CAL_TRIM: begin
				if (cnt == cfg.target_count) begin
					cal_ph = CAL_DONE;
				end else begin
					if (cnt > cfg.target_count) fine_q = fine_q - cfg.fine_step;
					else fine_q = fine_q + cfg.fine_step;
					fold_fine();
					write_fine();
					if (!(fine_q > '0 && fine_q < cfg.fine_high)) cal_ph = CAL_DONE;
				end
			end
			default: ;
		endcase
	endfunction

	// Advance the calibration by one request and build the result it owes.
	function automatic rslt_t predict(input cmd_t c);
		rslt_t r;
		strobe = 1'b0;
		case (c.command)
			CMD_START: begin
				speed_q = '0;
				coarse_q = '0;
				fine_q = FINE_W'(cfg.fine_start);
				write_fine();
				cal_ph = CAL_COARSE;
			end
			CMD_LEVEL: take_level(c.over_threshold);
			CMD_COUNT: take_count(c.freq_count);
			default: ;
		endcase
		r.speed_band = speed_q;
		r.coarse_code = coarse_q;
		r.fine_code = fine_dac;
		r.dac_update = strobe;
		case (cal_ph)
			CAL_COARSE, CAL_SPILL: r.next_request = REQ_LEVEL;
			CAL_SPEED, CAL_STEPDOWN, CAL_TRIM: r.next_request = REQ_COUNT;
			default: r.next_request = REQ_NONE;
		endcase
		r.cal_done = (cal_ph == CAL_DONE);
		return r;
	endfunction

	// Check results, track register writes and predict each accepted request.
	always @(posedge clk or negedge arst_n) begin
		rslt_t due;
		if (!arst_n) begin
			cfg.target_count = RST_TARGET_COUNT;
			cfg.fine_step = RST_FINE_STEP;
			cfg.fold_offset = RST_FOLD_OFFSET;
			cfg.fine_low = RST_FINE_LOW;
			cfg.fine_high = RST_FINE_HIGH;
			cfg.fine_start = RST_FINE_START;
			cal_ph = CAL_IDLE;
			speed_q = '0;
			coarse_q = '0;
			fine_q = '0;
			fine_dac = '0;
			strobe = 1'b0;
			codes_due.delete();
			n_fail = 0;
			n_pending = 0;
			predicted = '0;
		end else begin
			if (rslt_valid && rslt_ready) begin
				if (codes_due.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					due = codes_due.pop_front();
					check_field("speed_band", rslt_data.speed_band, due.speed_band);
					check_field("coarse_code", rslt_data.coarse_code, due.coarse_code);
					check_field("fine_code", rslt_data.fine_code, due.fine_code);
					check_field("dac_update", rslt_data.dac_update, due.dac_update);
					check_field("next_request", rslt_data.next_request, due.next_request);
					check_field("cal_done", rslt_data.cal_done, due.cal_done);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET_COUNT: cfg.target_count = cfg_wdata[COUNT_W-1:0];
					CFG_FINE_STEP:    cfg.fine_step = cfg_wdata[STEP_W-1:0];
					CFG_FOLD_OFFSET:  cfg.fold_offset = cfg_wdata[FOLD_W-1:0];
					CFG_FINE_LOW:     cfg.fine_low = cfg_wdata[FCODE_W-1:0];
					CFG_FINE_HIGH:    cfg.fine_high = cfg_wdata[FCODE_W-1:0];
					CFG_FINE_START:   cfg.fine_start = cfg_wdata[FCODE_W-1:0];
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				predicted = predict(cmd_data);
				codes_due.push_back(predicted);
			end
			n_pending = codes_due.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/pll_vco_band_calibrator_tb.sv @@
`default_nettype none

module pll_vco_band_calibrator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bvc_pkg::*;

	localparam int IDLE_PCT = 22;
	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_ITEMS = 100;
	localparam int SEQ_MAX_LEN = 80;

	// Codes the block does not define.
	localparam logic [1:0]           CMD_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_ready;
	cmd_t                  cmd_data = '0;
	logic                  rslt_valid;
	logic                  rslt_ready = 1'b0;
	rslt_t                 rslt_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int    n_fail;
	int    n_pending;
	rslt_t predicted;

	// Stimulus shaping shared by the sender and the receiver.
	bit                 quiet = 1'b0;
	bit                 hold_out = 1'b0;
	logic [COUNT_W-1:0] aim = RST_TARGET_COUNT;
	int                 seq_len;
	bit                 seq_weak;
	int                 seq_base;
	int                 seq_sg;
	int                 seq_cg;
	int                 seq_over_pct;
	int                 stall_cycles = 0;

	always #2 clk = ~clk;

	pll_vco_band_calibrator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.rslt_valid(rslt_valid),
		.rslt_ready(rslt_ready),
		.rslt_data (rslt_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	bvc_code_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.rslt_valid(rslt_valid),
		.rslt_ready(rslt_ready),
		.rslt_data (rslt_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.n_fail    (n_fail),
		.n_pending (n_pending),
		.predicted (predicted)
	);

	// Offer one request and hold it until the block takes it.
	task automatic put_request(input cmd_t c);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send(input logic [1:0] command, input logic over,
			input logic [COUNT_W-1:0] cnt);
		cmd_t c;
		c.command = command;
		c.over_threshold = over;
		c.freq_count = cnt;
		put_request(c);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == CFG_TARGET_COUNT) aim = data;
		@(negedge clk);
	endtask

	// Register settings for each phase of the run, extremes among them.
	task automatic set_config(input int p);
		case (p)
			1: begin
				write_reg(CFG_TARGET_COUNT, 16'($urandom_range(1000, 60000)));
				write_reg(CFG_FINE_STEP, 16'($urandom_range(8, 64)));
				write_reg(CFG_FOLD_OFFSET, 16'd300);
				write_reg(CFG_FINE_LOW, 16'd896);
				write_reg(CFG_FINE_HIGH, 16'd1152);
				write_reg(CFG_FINE_START, 16'd1024);
			end
			2: begin
				write_reg(CFG_TARGET_COUNT, 16'hFFFF);
				write_reg(CFG_FINE_STEP, 16'd255);
				write_reg(CFG_FOLD_OFFSET, 16'd1023);
				write_reg(CFG_FINE_LOW, 16'd2047);
				write_reg(CFG_FINE_HIGH, 16'd2047);
				write_reg(CFG_FINE_START, 16'd2047);
			end
			3: begin
				write_reg(CFG_TARGET_COUNT, 16'd0);
				write_reg(CFG_FINE_STEP, 16'd1);
				write_reg(CFG_FOLD_OFFSET, 16'd0);
				write_reg(CFG_FINE_LOW, 16'd0);
				write_reg(CFG_FINE_HIGH, 16'd0);
				write_reg(CFG_FINE_START, 16'd0);
			end
			4: begin
				write_reg(CFG_TARGET_COUNT, 16'($urandom_range(500, 65000)));
				write_reg(CFG_FINE_STEP, 16'd0);
				write_reg(CFG_FOLD_OFFSET, 16'($urandom_range(0, 1023)));
				write_reg(CFG_FINE_LOW, 16'($urandom_range(600, 1000)));
				write_reg(CFG_FINE_HIGH, 16'($urandom_range(1100, 1500)));
				write_reg(CFG_FINE_START, 16'd1024);
				write_reg(CFG_SPARE_LO, 16'($urandom));
				write_reg(CFG_SPARE_HI, 16'($urandom));
			end
			default: begin
				write_reg(CFG_TARGET_COUNT, 16'($urandom));
				write_reg(CFG_FINE_STEP, 16'($urandom));
				write_reg(CFG_FOLD_OFFSET, 16'($urandom));
				write_reg(CFG_FINE_LOW, 16'($urandom));
				write_reg(CFG_FINE_HIGH, 16'($urandom));
				write_reg(CFG_FINE_START, 16'($urandom));
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	// A crude VCO: the count grows with speed, coarse and fine, so that a
	// sweep crosses the target somewhere. Weak parts fall below it unless a draw returns the target or a random count.
	function automatic logic [COUNT_W-1:0] vco_count();
		int v;
		int r;
		r = int'($urandom_range(99));
		if (r < 12) return aim;
		if (r < 16) return 16'($urandom);
		if (seq_weak) begin
			if (aim == '0) return '0;
			v = int'(aim) - 1 - int'($urandom_range(0, (aim > 500) ? 500 : int'(aim) - 1));
		end else begin
			v = seq_base + int'(predicted.speed_band) * seq_sg
				+ int'(predicted.coarse_code) * seq_cg + int'(predicted.fine_code);
		end
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return 16'(v);
	endfunction

	// Mostly answer what the block asks for; the rest is restarts and noise.
	task automatic make_item(output cmd_t c, output bit counted);
		int r;
		r = int'($urandom_range(99));
		c.over_threshold = 1'($urandom);
		c.freq_count = 16'($urandom);
		counted = 1'b1;
		seq_len++;
		if (r < 8) begin
			c.command = 2'($urandom_range(1, 3));
			counted = 1'b0;
		end else if (r < 10 || predicted.next_request == REQ_NONE || seq_len > SEQ_MAX_LEN) begin
			c.command = CMD_START;
			seq_len = 0;
			seq_weak = ($urandom_range(3) == 0);
			seq_over_pct = seq_weak ? 3 : 25;
			seq_sg = int'($urandom_range(20, 300));
			seq_cg = int'($urandom_range(10, 120));
			seq_base = int'(aim) - int'($urandom_range(2, 24)) * seq_sg - 8 * seq_cg
				- 1024 + int'($urandom_range(0, 300));
		end else if (predicted.next_request == REQ_LEVEL) begin
			c.command = CMD_LEVEL;
			c.over_threshold = (int'($urandom_range(99)) < seq_over_pct);
		end else begin
			c.command = CMD_COUNT;
			c.freq_count = vco_count();
		end
	endtask

	// One phase of random traffic, then wait for the block to drain.
	task automatic run_random(input int n, input bit calm);
		cmd_t c;
		bit counted;
		int taken;
		taken = 0;
		quiet = calm;
		while (taken < n) begin
			make_item(c, counted);
			if (counted) begin
				taken++;
				if (taken == 40) hold_out = 1'b1;
				if (taken == 70) quiet = 1'b0;
			end
			put_request(c);
		end
		cmd_valid <= 1'b0;
		while (n_pending != 0) @(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off when asked.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_out) begin
				rslt_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end
			rslt_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Give up when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rslt_valid && rslt_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset settings: ignored commands while
		// idle, a short sweep, step-down, trim to an exact match, a command
		// after completion, restarts, and step-down with coarse at zero.
		send(CMD_SPARE, 1'b1, 16'hFFFF);
		send(CMD_LEVEL, 1'b1, 16'h0000);
		send(CMD_COUNT, 1'b0, 16'hFFFF);
		send(CMD_START, 1'b1, 16'hFFFF);
		send(CMD_COUNT, 1'b0, 16'hFFFF);
		send(CMD_LEVEL, 1'b0, 16'h0000);
		send(CMD_LEVEL, 1'b0, 16'h0000);
		send(CMD_LEVEL, 1'b1, 16'h0000);
		send(CMD_LEVEL, 1'b0, 16'hFFFF);
		send(CMD_COUNT, 1'b0, 16'h0000);
		send(CMD_COUNT, 1'b1, 16'hFFFF);
		send(CMD_COUNT, 1'b0, 16'h0000);
		send(CMD_COUNT, 1'b0, 16'h0000);
		send(CMD_COUNT, 1'b0, 16'h0007);
		send(CMD_START, 1'b0, 16'h0000);
		send(CMD_LEVEL, 1'b1, 16'h0000);
		send(CMD_COUNT, 1'b0, 16'h0000);
		send(CMD_START, 1'b0, 16'h5A5A);
		send(CMD_SPARE, 1'b0, 16'hA5A5);

		run_random(PHASE_ITEMS, 1'b0);
		for (int p = 1; p <= 6; p++) begin
			set_config(p);
			run_random(PHASE_ITEMS, p == 2);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0 && n_pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ pll_vco_band_calibrator.f @@
design/bvc_pkg.sv
design/bvc_cfg_regs.sv
design/bvc_rem_div.sv
design/bvc_core.sv
design/pll_vco_band_calibrator.sv
tb/bvc_code_checker.sv
tb/pll_vco_band_calibrator_tb.sv
